[rtl/core/lpht_pkg.sv]
// Shared types and constants for the linear probing hash table.
package lpht_pkg;

  // Fixed field widths of one item and one result.
  localparam int unsigned KEY_W      = 31;
  localparam int unsigned PAY_W      = 64;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SLOT_OUT_W = 4;

  // Home slot unit: reciprocal multiply, multiply-subtract and one correction.
  localparam int unsigned DIV_STEPS = 3;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int unsigned RECIP_W   = 32;

  // Queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_FOUND     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } fr_state_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_PROBE
  } bk_state_e;

  // One request as it travels from the front to the back.
  typedef struct packed {
    kind_e             kind;
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  payload;
  } lpht_item_t;

endpackage

[rtl/core/lpht_fifo.sv]
// Short queue that decouples the front from the back.
module lpht_fifo
  import lpht_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             not_empty_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

  logic [WIDTH-1:0]       entries_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;
  logic                   do_push, do_pop;

  assign full_o      = (count_q == CNT_FULL);
  assign not_empty_o = (count_q != '0);
  assign pop_data_o  = entries_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/core/lpht_front.sv]
// Front end: accepts requests and works out the home slot of each key.
module lpht_front
  import lpht_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = 16,
  parameter int unsigned SLOT_W      = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              kind_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [PAY_W-1:0]  payload_i,
  input  logic              clear_busy_i,
  output logic              push_o,
  output lpht_item_t        push_item_o,
  output logic [SLOT_W-1:0] push_home_o,
  input  logic              queue_full_i
);

  // The reciprocal is floor(2^RECIP_SHIFT / TABLE_SLOTS); with this shift it fits in
  // RECIP_W bits and the estimated quotient is at most one below the true one.
  localparam int unsigned FLOOR_LOG   = $clog2(TABLE_SLOTS + 1) - 1;
  localparam int unsigned RECIP_SHIFT = KEY_W + FLOOR_LOG;
  localparam int unsigned PROD_W      = KEY_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL  = (64'd1 << RECIP_SHIFT) / 64'(TABLE_SLOTS);
  localparam logic [RECIP_W-1:0]   RECIP     = RECIP_FULL[RECIP_W-1:0];
  localparam logic [SLOT_W:0]      SLOTS_EXT = (SLOT_W + 1)'(TABLE_SLOTS);
  localparam logic [DIV_CNT_W-1:0] CNT_LAST  = DIV_CNT_W'(DIV_STEPS - 1);

  fr_state_e              state_q, state_d;
  lpht_item_t             item_q;
  logic [PROD_W-1:0]      prod_q;
  logic [SLOT_W:0]        q_low;
  logic [2*SLOT_W+1:0]    qn_full;
  logic [SLOT_W:0]        est_q, est_d;
  logic [SLOT_W-1:0]      rem_q, rem_d;
  logic [DIV_CNT_W-1:0]   cnt_q;
  logic                   accept;

  assign push_item_o = item_q;
  assign push_home_o = rem_q;

  // The remainder estimate lies below twice the table size, so only its low bits are kept.
  always_comb begin
    q_low   = prod_q[RECIP_SHIFT +: SLOT_W+1];
    qn_full = {{(SLOT_W+1){1'b0}}, q_low} * {{(SLOT_W+1){1'b0}}, SLOTS_EXT};
    est_d   = item_q.key[SLOT_W:0] - qn_full[SLOT_W:0];
    rem_d   = (est_q >= SLOTS_EXT) ? SLOT_W'(est_q - SLOTS_EXT) : est_q[SLOT_W-1:0];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FR_IDLE: begin
        if (accept) begin
          state_d = FR_DIV;
        end
      end
      FR_DIV: begin
        if (cnt_q == CNT_LAST) begin
          state_d = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (!queue_full_i) begin
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall_o = 1'b1;
    push_o     = 1'b0;
    unique case (state_q)
      FR_IDLE: in_stall_o = clear_busy_i;
      FR_DIV:  in_stall_o = 1'b1;
      FR_PUSH: push_o     = 1'b1;
      default: in_stall_o = 1'b1;
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= '0;
      end else if (state_q == FR_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Request capture and the three remainder stages.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.kind    <= kind_e'(kind_i);
      item_q.key     <= key_i;
      item_q.payload <= payload_i;
    end else if (state_q == FR_DIV) begin
      prod_q <= PROD_W'(item_q.key) * PROD_W'(RECIP);
      est_q  <= est_d;
      rem_q  <= rem_d;
    end
  end

endmodule

[rtl/core/lpht_back.sv]
// Back end: clears the table after reset, then probes the slot memories per request.
module lpht_back
  import lpht_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = 16,
  parameter int unsigned SLOT_W      = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  output logic                  clear_busy_o,
  input  logic                  q_valid_i,
  input  lpht_item_t            q_item_i,
  input  logic [SLOT_W-1:0]     q_home_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SLOT_OUT_W-1:0] slot_o,
  output logic [PAY_W-1:0]      found_payload_o
);

  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(TABLE_SLOTS - 1);

  // Slot memories.
  logic             valid_mem [TABLE_SLOTS];
  logic [KEY_W-1:0] key_mem   [TABLE_SLOTS];
  logic [PAY_W-1:0] pay_mem   [TABLE_SLOTS];

  bk_state_e         state_q, state_d;
  lpht_item_t        work_q;
  logic [SLOT_W-1:0] cur_q, step_q, clr_idx_q;
  logic [SLOT_W-1:0] next_idx, rd_addr, vm_addr;
  logic              vm_we, vm_data, kp_we;
  logic              rd_valid_q;
  logic [KEY_W-1:0]  rd_key_q;
  logic [PAY_W-1:0]  rd_pay_q;
  logic              advance, load_out, out_free;

  // Probe decision on the slot read last cycle.
  logic              done, wr_entry;
  status_e           res_status;
  logic [SLOT_W-1:0] res_idx;
  logic [PAY_W-1:0]  res_pay;
  logic [SLOT_W+SLOT_OUT_W-1:0] res_idx_ext;

  logic              out_valid_q, out_valid_d;
  status_e           out_status_q;
  logic [SLOT_OUT_W-1:0] out_slot_q;
  logic [PAY_W-1:0]  out_pay_q;

  assign next_idx = (cur_q == LAST) ? '0 : cur_q + 1'b1;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    done       = 1'b0;
    wr_entry   = 1'b0;
    res_status = ST_NOT_FOUND;
    res_idx    = '0;
    res_pay    = '0;
    if (work_q.kind == KIND_INSERT) begin
      if (!rd_valid_q) begin
        done       = 1'b1;
        wr_entry   = 1'b1;
        res_status = ST_INSERTED;
        res_idx    = cur_q;
      end else if (step_q == LAST) begin
        done       = 1'b1;
        res_status = ST_FULL;
      end
    end else begin
      if (!rd_valid_q) begin
        done = 1'b1;
      end else if (rd_key_q == work_q.key) begin
        done       = 1'b1;
        res_status = ST_FOUND;
        res_idx    = cur_q;
        res_pay    = rd_pay_q;
      end else if (step_q == LAST) begin
        done = 1'b1;
      end
    end
  end

  // The result carries the low bits of the slot index.
  assign res_idx_ext = {{SLOT_OUT_W{1'b0}}, res_idx};

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_CLEAR: begin
        if (clr_idx_q == LAST) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid_i) begin
          state_d = BK_PROBE;
        end
      end
      BK_PROBE: begin
        if (done && out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_CLEAR;
    endcase
  end

  // Outputs: memory ports, queue pop and result load.
  always_comb begin
    clear_busy_o = 1'b0;
    q_pop_o      = 1'b0;
    rd_addr      = cur_q;
    vm_we        = 1'b0;
    vm_addr      = cur_q;
    vm_data      = 1'b1;
    kp_we        = 1'b0;
    load_out     = 1'b0;
    advance      = 1'b0;
    unique case (state_q)
      BK_CLEAR: begin
        clear_busy_o = 1'b1;
        vm_we        = 1'b1;
        vm_addr      = clr_idx_q;
        vm_data      = 1'b0;
      end
      BK_IDLE: begin
        rd_addr = q_home_i;
        q_pop_o = q_valid_i;
      end
      BK_PROBE: begin
        if (done) begin
          // Hold the current slot until the output register is free.
          if (out_free) begin
            load_out = 1'b1;
            vm_we    = wr_entry;
            kp_we    = wr_entry;
          end
        end else begin
          advance = 1'b1;
          rd_addr = next_idx;
        end
      end
      default: clear_busy_o = 1'b1;
    endcase
  end

  // Output register next value.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_idx_q   <= '0;
      cur_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == BK_CLEAR) begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
      if (q_pop_o) begin
        cur_q  <= q_home_i;
        step_q <= '0;
      end else if (advance) begin
        cur_q  <= next_idx;
        step_q <= step_q + 1'b1;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      work_q <= q_item_i;
    end
    if (load_out) begin
      out_status_q <= res_status;
      out_slot_q   <= res_idx_ext[SLOT_OUT_W-1:0];
      out_pay_q    <= res_pay;
    end
  end

  // Valid bit memory with registered read.
  always_ff @(posedge clk_i) begin
    if (vm_we) begin
      valid_mem[vm_addr] <= vm_data;
    end
    rd_valid_q <= valid_mem[rd_addr];
  end

  // Key memory with registered read.
  always_ff @(posedge clk_i) begin
    if (kp_we) begin
      key_mem[cur_q] <= work_q.key;
    end
    rd_key_q <= key_mem[rd_addr];
  end

  // Payload memory with registered read.
  always_ff @(posedge clk_i) begin
    if (kp_we) begin
      pay_mem[cur_q] <= work_q.payload;
    end
    rd_pay_q <= pay_mem[rd_addr];
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign slot_o          = out_slot_q;
  assign found_payload_o = out_pay_q;

endmodule

[rtl/core/linear_probe_hash_table.sv]
// Top level of the linear probing hash table: front, queue and back.
//
//   Channel  Handshake                 Payload
//   in       in_valid_i / in_stall_o   kind_i, key_i, payload_i
//   out      out_valid_o / out_stall_i status_o, slot_o, found_payload_o
//
// The front takes a new request only after it has pushed the last one to the
// queue; the home slot comes from a reciprocal multiply, a multiply-subtract
// and one correction step. The back probes 1 to TABLE_SLOTS slots per request;
// it reads one slot per cycle from its memories, holding the last slot while
// the output register is stalled. After reset the back clears the valid bits
// of all TABLE_SLOTS slots, and no request is accepted during that pass.
// A stalled result holds in the output register while the front and queue go on.
module linear_probe_hash_table
  import lpht_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  kind_i,
  input  logic [KEY_W-1:0]      key_i,
  input  logic [PAY_W-1:0]      payload_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SLOT_OUT_W-1:0] slot_o,
  output logic [PAY_W-1:0]      found_payload_o
);

  localparam int unsigned SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int unsigned ENTRY_W = SLOT_W + $bits(lpht_item_t);

  logic              clear_busy;
  logic              push, queue_full;
  lpht_item_t        push_item;
  logic [SLOT_W-1:0] push_home;
  logic              pop, q_valid;
  logic [ENTRY_W-1:0] q_data;
  lpht_item_t        q_item;
  logic [SLOT_W-1:0] q_home;

  lpht_front #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .SLOT_W     (SLOT_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .key_i       (key_i),
    .payload_i   (payload_i),
    .clear_busy_i(clear_busy),
    .push_o      (push),
    .push_item_o (push_item),
    .push_home_o (push_home),
    .queue_full_i(queue_full)
  );

  lpht_fifo #(
    .WIDTH(ENTRY_W)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({push_home, push_item}),
    .full_o     (queue_full),
    .pop_i      (pop),
    .not_empty_o(q_valid),
    .pop_data_o (q_data)
  );

  assign q_item = q_data[$bits(lpht_item_t)-1:0];
  assign q_home = q_data[ENTRY_W-1:$bits(lpht_item_t)];

  lpht_back #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .SLOT_W     (SLOT_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .clear_busy_o   (clear_busy),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_home_i       (q_home),
    .q_pop_o        (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .found_payload_o(found_payload_o)
  );

endmodule

[sim/tb.sv]
// Testbench for the linear probing hash table: directed and random traffic checked against a shadow table.
module tb;
  import lpht_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned RANDOM_ITEMS = 1690;
  localparam int unsigned FILL_START = 1150;
  localparam int unsigned CALM_TAIL = 150;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  // One request and whether it waits until no result is outstanding.
  typedef struct {
    kind_e            kind;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
    bit               wait_drain;
  } request_t;

  typedef struct {
    status_e               status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [PAY_W-1:0]      pay;
  } answer_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  kind_e                 kind = KIND_INSERT;
  logic [KEY_W-1:0]      key = '0;
  logic [PAY_W-1:0]      payload = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_OUT_W-1:0] slot;
  logic [PAY_W-1:0]      found_payload;

  // Shadow copy of the table contents.
  bit               tbl_used [SLOTS];
  logic [KEY_W-1:0] tbl_key  [SLOTS];
  logic [PAY_W-1:0] tbl_pay  [SLOTS];

  request_t requests[$];
  answer_t  answers_due[$];
  request_t cur_req;
  int unsigned mismatches = 0;
  bit calm_tail = 1'b0;

  wire in_xfer  = in_valid && !in_stall;
  wire out_xfer = out_valid && !out_stall;

  linear_probe_hash_table #(
    .TABLE_SLOTS(SLOTS)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (kind),
    .key_i          (key),
    .payload_i      (payload),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .slot_o         (slot),
    .found_payload_o(found_payload)
  );

  // Probes the shadow table for one request and applies an insert to it.
  function automatic answer_t probe_table(request_t req);
    answer_t     ans;
    int unsigned home;
    int unsigned idx;
    bit          done;
    ans.status = (req.kind == KIND_INSERT) ? ST_FULL : ST_NOT_FOUND;
    ans.slot = '0;
    ans.pay = '0;
    home = req.key % SLOTS;
    done = 1'b0;
    for (int unsigned step = 0; step < SLOTS && !done; step++) begin
      idx = (home + step) % SLOTS;
      if (req.kind == KIND_INSERT) begin
        if (!tbl_used[idx]) begin
          tbl_used[idx] = 1'b1;
          tbl_key[idx] = req.key;
          tbl_pay[idx] = req.pay;
          ans.status = ST_INSERTED;
          ans.slot = idx[SLOT_OUT_W-1:0];
          done = 1'b1;
        end
      end else if (!tbl_used[idx]) begin
        // An empty slot ends the search.
        done = 1'b1;
      end else if (tbl_key[idx] == req.key) begin
        ans.status = ST_FOUND;
        ans.slot = idx[SLOT_OUT_W-1:0];
        ans.pay = tbl_pay[idx];
        done = 1'b1;
      end
    end
    return ans;
  endfunction

  function automatic request_t make_req(kind_e k, logic [KEY_W-1:0] kv, logic [PAY_W-1:0] pv,
                                        bit drain);
    request_t req;
    req.kind = k;
    req.key = kv;
    req.pay = pv;
    req.wait_drain = drain;
    return req;
  endfunction

  function automatic logic [PAY_W-1:0] rand_pay();
    return {$urandom, $urandom};
  endfunction

  // Clock.
  initial begin
    forever #1 clk = ~clk;
  end

  // Sender: presents queued requests, holds them while stalled, idles in bursts.
  always @(posedge clk) begin
    request_t    nxt;
    int unsigned gap_left;
    int unsigned gap_pct;
    int unsigned sent;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
      gap_pct = 0;
      sent = 0;
    end else begin
      calm_tail = requests.size() < CALM_TAIL;
      // Predict the result as soon as the transfer happens.
      if (in_xfer) begin
        answers_due.push_back(probe_table(cur_req));
        sent++;
        if (sent % 64 == 0) gap_pct = 10 * $urandom_range(0, 3);
        if (!calm_tail && $urandom_range(0, 99) < gap_pct) gap_left = $urandom_range(1, 16);
      end
      if (in_valid && in_stall) begin
        // Hold the stalled request as it is.
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (requests.size() != 0 &&
                   !(requests[0].wait_drain && answers_due.size() != 0)) begin
        nxt = requests.pop_front();
        cur_req = nxt;
        in_valid <= 1'b1;
        kind <= nxt.kind;
        key <= nxt.key;
        payload <= nxt.pay;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each result transfer and stalls in bursts.
  always @(posedge clk) begin
    answer_t     want;
    int unsigned stall_left;
    int unsigned stall_pct;
    int unsigned got;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      stall_pct = 0;
      got = 0;
    end else begin
      if (out_xfer) begin
        if (answers_due.size() == 0) begin
          $error("result with no request outstanding: status %0d slot %0d", status, slot);
          mismatches++;
        end else begin
          want = answers_due.pop_front();
          if (status !== want.status) begin
            $error("field status: expected %0d, got %0d", want.status, status);
            mismatches++;
          end
          if (slot !== want.slot) begin
            $error("field slot: expected %0d, got %0d", want.slot, slot);
            mismatches++;
          end
          if (found_payload !== want.pay) begin
            $error("field found_payload: expected %h, got %h", want.pay, found_payload);
            mismatches++;
          end
        end
        got++;
        if (got % 64 == 0) stall_pct = 4 * $urandom_range(0, 3);
      end
      if (stall_left != 0) begin
        stall_left--;
      end else if (!calm_tail && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 16);
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Ends the run when no transfer happens on either side for too long.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    do begin
      @(posedge clk);
      if (in_xfer || out_xfer) quiet_cycles = 0;
      else quiet_cycles++;
    end while (quiet_cycles < WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [KEY_W-1:0] pool[$];
    logic [KEY_W-1:0] kv;
    logic [31:0]      r;
    kind_e            k;
    int unsigned      insert_pct;
    int unsigned      pick;

    // Directed: empty table, key extremes, wrap-around, duplicates, early stop.
    requests.push_back(make_req(KIND_LOOKUP, '0, rand_pay(), 1'b0));
    requests.push_back(make_req(KIND_INSERT, '0, '1, 1'b0));
    requests.push_back(make_req(KIND_INSERT, KEY_MAX, '0, 1'b0));
    requests.push_back(make_req(KIND_INSERT, KEY_MAX, 64'h0123_4567_89ab_cdef, 1'b0));
    requests.push_back(make_req(KIND_LOOKUP, KEY_MAX, rand_pay(), 1'b0));
    requests.push_back(make_req(KIND_INSERT, 31'd16, 64'ha5a5_a5a5_5a5a_5a5a, 1'b0));
    requests.push_back(make_req(KIND_LOOKUP, 31'd16, '1, 1'b0));
    requests.push_back(make_req(KIND_LOOKUP, 31'd32, '0, 1'b0));
    requests.push_back(make_req(KIND_LOOKUP, '0, '1, 1'b0));
    requests.push_back(make_req(KIND_INSERT, 31'h7fff_fff0, rand_pay(), 1'b0));
    requests.push_back(make_req(KIND_LOOKUP, 31'h7fff_fff0, rand_pay(), 1'b0));
    requests.push_back(make_req(KIND_LOOKUP, 31'h7fff_ffef, rand_pay(), 1'b0));
    pool = '{'0, KEY_MAX, 31'd16, 31'h7fff_fff0};

    // Random: a slowly filling table first, then enough inserts to fill it and overflow.
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      insert_pct = (i < FILL_START) ? 1 : 25;
      k = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_LOOKUP;
      pick = $urandom_range(0, 3);
      r = $urandom;
      if (pick <= 1 && (k == KIND_LOOKUP || pick == 0)) begin
        kv = pool[$urandom_range(0, pool.size() - 1)];
      end else if (pick <= 2) begin
        // Same home slot as a known key, different upper bits.
        kv = pool[$urandom_range(0, pool.size() - 1)] + {r[26:0], 4'b0000};
      end else begin
        kv = r[KEY_W-1:0];
      end
      if (k == KIND_INSERT) pool.push_back(kv);
      requests.push_back(make_req(k, kv, rand_pay(), i == 0 || i == 800));
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (requests.size() != 0 || in_valid || answers_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
